// File: rtl/core/kld_pkg.sv
// ----------------------------------------------------------------------------
// kld_pkg
// shared types and constants of the k-th largest distinct value selector
// ----------------------------------------------------------------------------
package kld_pkg;

    localparam int VALUE_W    = 32;
    localparam int RANK_W     = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [RANK_W-1:0]         rank_t;
    typedef logic [APB_ADDR_W-1:0]     apb_addr_t;
    typedef logic [APB_DATA_W-1:0]     apb_data_t;

    localparam apb_addr_t RANK_K_ADDR  = 3'd0;
    localparam rank_t     RANK_K_RESET = 11'd1;
    localparam value_t    INT_MIN      = 32'sh8000_0000;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_DRAIN,
        S_CHECK,
        S_EMIT
    } kld_state_t;

endpackage

// File: rtl/core/kld_req_if.sv
// ----------------------------------------------------------------------------
// kld_req_if
// request channel: one data value and its last flag
// ----------------------------------------------------------------------------
interface kld_req_if;
    import kld_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

// File: rtl/core/kld_res_if.sv
// ----------------------------------------------------------------------------
// kld_res_if
// result channel: selected value and found flag
// ----------------------------------------------------------------------------
interface kld_res_if;
    import kld_pkg::*;

    logic   valid;
    logic   ready;
    value_t kth_value;
    logic   found;

    modport source (output valid, output kth_value, output found, input ready);
    modport sink   (input valid, input kth_value, input found, output ready);

endinterface

// File: rtl/core/kld_ram.sv
// ----------------------------------------------------------------------------
// kld_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module kld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/kth_largest_distinct_select_core.sv
// ----------------------------------------------------------------------------
// kth_largest_distinct_select_core
// selects the k-th largest distinct value of a loaded set of signed values
// ----------------------------------------------------------------------------
// Values are loaded one per cycle into a single memory until a request with
// last set arrives; that request's value is stored too, up to MAX_VALUES held
// values. The search then makes up to rank_k passes over the N stored values
// through the memory's one read port, each pass keeping the greatest value
// strictly below the previous pass's result. A pass reads the N values in
// S_READ, then goes through S_DRAIN and S_CHECK; a search ends early when the
// distinct values run out, and no requests are taken meanwhile. The result
// waits in an output register, so loading of the next set can start before it
// is taken. rank_k = 0 gives a result without any pass.
module kth_largest_distinct_select_core #(
    parameter int MAX_VALUES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    kld_req_if.sink                    req,
    kld_res_if.source                  res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  kld_pkg::apb_addr_t         paddr,
    input  kld_pkg::apb_data_t         pwdata,
    output kld_pkg::apb_data_t         prdata,
    output logic                       pready
);
    import kld_pkg::*;

    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VALUES);

    kld_state_t    state_reg, state_next;
    rank_t         rank_k_reg, rank_k_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          rd_valid_reg, rd_valid_next;
    value_t        upper_reg, upper_next;
    logic          bound_reg, bound_next;
    value_t        best_reg, best_next;
    logic          best_valid_reg, best_valid_next;
    rank_t         pass_reg, pass_next;
    value_t        pend_value_reg, pend_value_next;
    logic          pend_found_reg, pend_found_next;
    logic          res_valid_reg, res_valid_next;
    value_t        res_value_reg, res_value_next;
    logic          res_found_reg, res_found_next;

    logic          req_fire;
    logic          cfg_wr;
    logic          wr_en;
    logic          rd_en;
    logic [VALUE_W-1:0] rd_data;
    value_t        rd_val;
    logic          cand;
    logic          upd;
    logic          last_addr;
    logic          last_pass;
    logic          res_free;

    kld_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_VALUES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    assign req.ready     = (state_reg == S_LOAD);
    assign req_fire      = req.valid && req.ready;
    assign wr_en         = req_fire && (cnt_reg < CNT_MAX);
    assign rd_en         = (state_reg == S_READ);
    assign rd_val        = value_t'(rd_data);
    assign cand          = !bound_reg || (rd_val < upper_reg);
    assign upd           = rd_valid_reg && cand && (!best_valid_reg || (rd_val > best_reg));
    assign last_addr     = ((CW'(rd_addr_reg) + CW'(1)) == cnt_reg);
    assign last_pass     = (RANK_W'(pass_reg + RANK_W'(1)) == rank_k_reg);
    assign res_free      = !res_valid_reg || res.ready;

    assign res.valid     = res_valid_reg;
    assign res.kth_value = res_value_reg;
    assign res.found     = res_found_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == RANK_K_ADDR[APB_ADDR_W-1:2]);
    assign prdata = (paddr[APB_ADDR_W-1:2] == RANK_K_ADDR[APB_ADDR_W-1:2])
                    ? APB_DATA_W'(rank_k_reg) : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (req_fire && req.last)
                begin
                    state_next = (rank_k_reg == '0) ? S_EMIT : S_READ;
                end
            end
            S_READ:
            begin
                if (last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = (!best_valid_reg || last_pass) ? S_EMIT : S_READ;
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rank_k_next     = cfg_wr ? pwdata[RANK_W-1:0] : rank_k_reg;
        cnt_next        = cnt_reg;
        rd_addr_next    = rd_addr_reg;
        rd_valid_next   = 1'b0;
        upper_next      = upper_reg;
        bound_next      = bound_reg;
        best_next       = upd ? rd_val : best_reg;
        best_valid_next = best_valid_reg || upd;
        pass_next       = pass_reg;
        pend_value_next = pend_value_reg;
        pend_found_next = pend_found_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (wr_en)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (req_fire && req.last)
                begin
                    rd_addr_next    = '0;
                    bound_next      = 1'b0;
                    upper_next      = '0;
                    best_next       = INT_MIN;
                    best_valid_next = 1'b0;
                    pass_next       = '0;
                    pend_value_next = INT_MIN;
                    pend_found_next = 1'b0;
                end
            end
            S_READ:
            begin
                rd_valid_next = 1'b1;
                rd_addr_next  = rd_addr_reg + AW'(1);
            end
            S_DRAIN:
            begin
            end
            S_CHECK:
            begin
                rd_addr_next = '0;
                if (!best_valid_reg)
                begin
                    pend_value_next = INT_MIN;
                    pend_found_next = 1'b0;
                end
                else if (last_pass)
                begin
                    pend_value_next = best_reg;
                    pend_found_next = 1'b1;
                end
                else
                begin
                    upper_next      = best_reg;
                    bound_next      = 1'b1;
                    best_next       = INT_MIN;
                    best_valid_next = 1'b0;
                    pass_next       = RANK_W'(pass_reg + RANK_W'(1));
                end
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_value_next = pend_value_reg;
                    res_found_next = pend_found_reg;
                    cnt_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            rank_k_reg     <= RANK_K_RESET;
            cnt_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            bound_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
            pass_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rank_k_reg     <= rank_k_next;
            cnt_reg        <= cnt_next;
            rd_valid_reg   <= rd_valid_next;
            bound_reg      <= bound_next;
            best_valid_reg <= best_valid_next;
            pass_reg       <= pass_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        upper_reg      <= upper_next;
        best_reg       <= best_next;
        pend_value_reg <= pend_value_next;
        pend_found_reg <= pend_found_next;
        res_value_reg  <= res_value_next;
        res_found_reg  <= res_found_next;
    end

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("stored count above capacity");

    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> !wr_en)
        else $error("store written during search");

    a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == S_READ))
        else $error("read data without a read");

    a_not_found_value: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_found_reg) |-> (res_value_reg == INT_MIN))
        else $error("not-found result carries a value");

    a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (cnt_reg != '0))
        else $error("search over an empty store");

endmodule

// File: test/tb_kth_largest_distinct_select_core.sv
// ----------------------------------------------------------------------------
// tb_kth_largest_distinct_select_core
// self-checking bench for the k-th largest distinct value selector
// ----------------------------------------------------------------------------
// A short table of directed sets covers the value extremes, rank zero, ranks
// above the distinct count and the most negative value as a member. Random
// sets of varied size and spread follow under three pacing phases, then one
// set that overflows the store. Each result is checked in order, for pinned
// rows against the table, else a repeated floor search model run beside it.
module tb_kth_largest_distinct_select_core;
    import kld_pkg::*;

    localparam int     CLK_PERIOD      = 12;
    localparam int     STORE_DEPTH     = 1024;
    localparam int     ITEMS_PER_PHASE = 60;
    localparam int     LONG_HOLD       = 800;
    localparam int     SETTLE_CYCLES   = 4;
    localparam int     END_CYCLES      = 20;
    localparam int     TIMEOUT_CYCLES  = 3000000;
    localparam value_t VALUE_MAX       = 32'sh7fff_ffff;

    typedef enum logic { ROW_VALUE, ROW_RANK } row_kind_t;
    typedef enum int { SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGES } spread_t;

    typedef struct packed {
        value_t kth_value;
        logic   found;
    } result_t;

    typedef struct {
        row_kind_t kind;
        value_t    value;
        logic      last;
        logic      pinned;
        value_t    want_value;
        logic      want_found;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 29;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_VALUE, 32'sd5,     1'b1, 1'b1, 32'sd5,  1'b1},
        '{ROW_VALUE, INT_MIN,    1'b1, 1'b1, INT_MIN, 1'b1},
        '{ROW_RANK,  32'sd2,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, VALUE_MAX,  1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, VALUE_MAX,  1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, INT_MIN,    1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, VALUE_MAX,  1'b1, 1'b1, INT_MIN, 1'b1},
        '{ROW_RANK,  32'sd0,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, 32'sd7,     1'b1, 1'b1, INT_MIN, 1'b0},
        '{ROW_RANK,  32'sd3,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, 32'sd1,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, 32'sd2,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, 32'sd2,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, 32'sd1,     1'b1, 1'b1, INT_MIN, 1'b0},
        '{ROW_RANK,  32'sd1024,  1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, 32'sd3,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, -32'sd3,    1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, 32'sd0,     1'b1, 1'b1, INT_MIN, 1'b0},
        '{ROW_RANK,  32'sd2047,  1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, 32'sd0,     1'b1, 1'b1, INT_MIN, 1'b0},
        '{ROW_RANK,  32'sd3,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, -32'sd1,    1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, 32'sd0,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, INT_MIN,    1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, VALUE_MAX,  1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, -32'sd2,    1'b1, 1'b0, INT_MIN, 1'b0},
        '{ROW_RANK,  32'sd1,     1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, INT_MIN,    1'b0, 1'b0, INT_MIN, 1'b0},
        '{ROW_VALUE, INT_MIN,    1'b1, 1'b1, INT_MIN, 1'b1}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    apb_addr_t   paddr;
    apb_data_t   pwdata;
    apb_data_t   prdata;
    logic        pready;

    kld_req_if req_ch ();
    kld_res_if res_ch ();

    value_t      held_values[$];
    result_t     awaited_results[$];
    rank_t       rank_setting = RANK_K_RESET;
    int unsigned mismatch_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned quiet_left = 0;

    kth_largest_distinct_select_core #(
        .MAX_VALUES (STORE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Verification failed");
        $finish;
    end

    // repeated floor search over the held set
    function automatic result_t predict_kth();
        value_t  bound;
        logic    bounded;
        value_t  best;
        logic    have;
        result_t outcome;
        bound   = '0;
        bounded = 1'b0;
        best    = INT_MIN;
        have    = 1'b0;
        for (int p = 0; p < int'(rank_setting); p++)
        begin
            best = INT_MIN;
            have = 1'b0;
            foreach (held_values[i])
            begin
                if (bounded && !(held_values[i] < bound))
                    continue;
                if (!have || held_values[i] > best)
                begin
                    best = held_values[i];
                    have = 1'b1;
                end
            end
            if (!have)
                break;
            bound   = best;
            bounded = 1'b1;
        end
        if (rank_setting != 0 && have)
            outcome = '{kth_value: best, found: 1'b1};
        else
            outcome = '{kth_value: INT_MIN, found: 1'b0};
        return outcome;
    endfunction

    function automatic value_t pick_value(input spread_t spread);
        value_t pick;
        int     near;
        near = $urandom_range(8);
        case (spread)
            SPREAD_NARROW: pick = near - 4;
            SPREAD_EDGES:
                case ($urandom_range(5))
                    0:       pick = INT_MIN;
                    1:       pick = VALUE_MAX;
                    2:       pick = '0;
                    3:       pick = -32'sd1;
                    default: pick = $urandom;
                endcase
            default: pick = $urandom;
        endcase
        return pick;
    endfunction

    function automatic rank_t pick_rank();
        rank_t rank;
        case ($urandom_range(9))
            0:       rank = '0;
            1:       rank = 11'd1;
            2:       rank = 11'd1024;
            3:       rank = 11'd2047;
            4:       rank = rank_t'($urandom_range(2047));
            default: rank = rank_t'($urandom_range(12, 1));
        endcase
        return rank;
    endfunction

    task automatic send_value(input value_t v, input logic last, input logic pinned,
                              input result_t pin);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.value <= v;
        req_ch.last  <= last;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (held_values.size() < STORE_DEPTH)
            held_values = {held_values, v};
        if (last)
        begin
            awaited_results = {awaited_results, (pinned ? pin : predict_kth())};
            held_values.delete();
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write then read back over the config port
    task automatic program_rank(input rank_t rank);
        apb_data_t word;
        word = $urandom;
        word[RANK_W-1:0] = rank;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RANK_K_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[RANK_W-1:0] !== rank)
        begin
            $display("%0t: rank_k readback mismatch, expected %0d, actual %0d",
                     $time, rank, prdata[RANK_W-1:0]);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        rank_setting = rank;
    endtask

    task automatic send_set(input int unsigned size, input spread_t spread);
        for (int unsigned n = 0; n < size; n++)
            send_value(pick_value(spread), n == size - 1, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin : sink_pace
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (quiet_left != 0)
        begin
            res_ch.ready <= 1'b0;
            quiet_left   <= quiet_left - 1;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen    <= hold_asks;
            quiet_left   <= LONG_HOLD;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %0d found %0b",
                         $time, res_ch.kth_value, res_ch.found);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (res_ch.kth_value !== want.kth_value)
                begin
                    $display("%0t: kth_value mismatch, expected %0d, actual %0d",
                             $time, want.kth_value, res_ch.kth_value);
                    mismatch_count++;
                end
                if (res_ch.found !== want.found)
                begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, res_ch.found);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned phase_items;
        int unsigned size;
        spread_t     spread;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.value  <= '0;
        req_ch.last   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_RANK)
            begin
                drain_results();
                program_rank(rank_t'(directed_rows[r].value));
            end
            else
                send_value(directed_rows[r].value, directed_rows[r].last,
                           directed_rows[r].pinned,
                           '{kth_value: directed_rows[r].want_value,
                             found: directed_rows[r].want_found});
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 13 : (phase == 1) ? 47 : 0;
            sink_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 13 : 0;
            phase_items   = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                drain_results();
                program_rank(pick_rank());
                // long receiver stall while the sender keeps pushing
                if (phase == 2 && phase_items == 0)
                    hold_asks++;
                repeat ($urandom_range(8, 3))
                begin
                    size   = ($urandom_range(19) == 0) ? $urandom_range(64, 17)
                                                       : $urandom_range(16, 1);
                    spread = spread_t'($urandom_range(2));
                    send_set(size, spread);
                    phase_items += size;
                end
            end
        end

        // store overflow, the last values including the final one are dropped
        drain_results();
        program_rank(11'd3);
        send_set(STORE_DEPTH + 3, SPREAD_WIDE);

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/kld_pkg.sv
rtl/core/kld_req_if.sv
rtl/core/kld_res_if.sv
rtl/core/kld_ram.sv
rtl/core/kth_largest_distinct_select_core.sv
test/tb_kth_largest_distinct_select_core.sv
